>>> rtl/core/twm_pkg.sv
// Shared types and constants for the traffic window monitor.
`timescale 1ns / 1ps
package twm_pkg;

  localparam int KEY_BITS = 48;
  localparam int CFG_BITS = 24;
  localparam int IDX_BITS = 2;

  localparam logic [3:0]  IP_V4     = 4'd4;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [19:0] MEGA      = 20'd1000000;

  localparam logic [23:0] PPS_LIMIT_RESET  = 24'd1000;
  localparam logic [16:0] MBPS_LIMIT_RESET = 17'd100;
  localparam logic [8:0]  CONN_LIMIT_RESET = 9'd500;
  localparam logic [15:0] MTU_BYTES_RESET  = 16'd1500;

  typedef enum logic [IDX_BITS-1:0] {
    REG_PPS_LIMIT  = 2'd0,
    REG_MBPS_LIMIT = 2'd1,
    REG_CONN_LIMIT = 2'd2,
    REG_MTU_BYTES  = 2'd3
  } twm_reg_t;

  // Control bits of a packet token as it moves down the cell row.
  typedef struct packed {
    logic valid;
    logic ipv4;
    logic tcp;
    logic close;
    logic hit;
  } twm_ctl_t;

endpackage

>>> rtl/core/twm_cell.sv
// One connection table cell: holds one key and passes the packet token on.
`timescale 1ns / 1ps
module twm_cell #(
  parameter int CNT_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  twm_pkg::twm_ctl_t              ctl_prev,
  input  logic [twm_pkg::KEY_BITS-1:0]   key_prev,
  input  logic [CNT_BITS-1:0]            cnt_prev,
  output twm_pkg::twm_ctl_t              ctl,
  output logic [twm_pkg::KEY_BITS-1:0]   key,
  output logic [CNT_BITS-1:0]            cnt
);
  import twm_pkg::*;

  logic                used;
  logic [KEY_BITS-1:0] stored;
  logic                active;
  logic                probe;
  logic                match;
  logic                claim;
  logic                seen;
  twm_ctl_t            ctl_next;

  assign active = ctl_prev.valid && ctl_prev.ipv4;
  assign probe  = active && ctl_prev.tcp && !ctl_prev.hit;
  assign match  = probe && used && (stored == key_prev);
  // Valid cells form a prefix, so the first empty cell a key reaches is its slot.
  assign claim  = probe && !used;
  assign seen   = active && (used || claim);

  always_comb begin
    ctl_next     = ctl_prev;
    ctl_next.hit = ctl_prev.hit | match | claim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      ctl  <= '0;
    end else if (adv) begin
      ctl <= ctl_next;
      // a closing packet empties the cell behind it
      if (active && ctl_prev.close) begin
        used <= 1'b0;
      end else if (claim) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key <= key_prev;
      cnt <= cnt_prev + {{(CNT_BITS-1){1'b0}}, seen};
      if (claim) begin
        stored <= key_prev;
      end
    end
  end

endmodule

>>> rtl/core/twm_chain.sv
// Row of connection table cells, one token step per cycle while adv is high.
`timescale 1ns / 1ps
module twm_chain #(
  parameter int ENTRIES  = 512,
  parameter int CNT_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  twm_pkg::twm_ctl_t            ctl_in,
  input  logic [twm_pkg::KEY_BITS-1:0] key_in,
  output twm_pkg::twm_ctl_t            ctl_out,
  output logic [CNT_BITS-1:0]          cnt_out
);
  import twm_pkg::*;

  twm_ctl_t            ctl_link [ENTRIES+1];
  logic [KEY_BITS-1:0] key_link [ENTRIES+1];
  logic [CNT_BITS-1:0] cnt_link [ENTRIES+1];

  assign ctl_link[0] = ctl_in;
  assign key_link[0] = key_in;
  assign cnt_link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    twm_cell #(
      .CNT_BITS (CNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_prev (ctl_link[i]),
      .key_prev (key_link[i]),
      .cnt_prev (cnt_link[i]),
      .ctl      (ctl_link[i+1]),
      .key      (key_link[i+1]),
      .cnt      (cnt_link[i+1])
    );
  end

  assign ctl_out = ctl_link[ENTRIES];
  assign cnt_out = cnt_link[ENTRIES];

endmodule

>>> rtl/core/twm_report.sv
// Window counters, threshold compares and the result register.
`timescale 1ns / 1ps
module twm_report #(
  parameter int ENTRIES    = 512,
  parameter int COUNT_BITS = 24,
  parameter int CNT_BITS   = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  twm_pkg::twm_ctl_t ctl_exit,
  input  logic [CNT_BITS-1:0] cnt_exit,
  input  logic [23:0]       pps_limit,
  input  logic [16:0]       mbps_limit,
  input  logic [8:0]        conn_limit,
  input  logic [15:0]       mtu_bytes,
  output logic              rep_valid,
  output logic              connection_alert,
  output logic              rate_alert,
  output logic              bandwidth_alert,
  output logic              window_closed,
  output logic [23:0]       packets_reported,
  output logic [23:0]       tcp_reported,
  output logic [9:0]        connections_reported
);
  import twm_pkg::*;

  localparam int CONN_W = (CNT_BITS > 9) ? CNT_BITS : 9;
  localparam int PPS_W  = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam int PROD_W = COUNT_BITS + 16;
  localparam int LIM_W  = 37;
  localparam int BW_W   = (PROD_W + 3 > LIM_W) ? PROD_W + 3 : LIM_W;

  logic [COUNT_BITS-1:0] pkt_count;
  logic [COUNT_BITS-1:0] tcp_count;
  logic [COUNT_BITS-1:0] pkt_inc;
  logic [COUNT_BITS-1:0] tcp_inc;
  logic                  live;
  logic                  closing;
  logic [LIM_W-1:0]      lim;

  logic                  s1_valid;
  logic                  s1_alert;
  logic                  s1_close;
  logic [COUNT_BITS-1:0] s1_pkt;
  logic [COUNT_BITS-1:0] s1_tcp;
  logic [CNT_BITS-1:0]   s1_conn;

  logic                  s2_valid;
  logic                  s2_alert;
  logic                  s2_close;
  logic                  s2_rate;
  logic [COUNT_BITS-1:0] s2_pkt;
  logic [COUNT_BITS-1:0] s2_tcp;
  logic [CNT_BITS-1:0]   s2_conn;
  logic [PROD_W-1:0]     s2_prod;

  assign pkt_inc = (pkt_count == {COUNT_BITS{1'b1}}) ? pkt_count
                                                     : pkt_count + COUNT_BITS'(1);
  assign tcp_inc = (tcp_count == {COUNT_BITS{1'b1}}) ? tcp_count
                                                     : tcp_count + COUNT_BITS'(1);
  assign live    = ctl_exit.valid && ctl_exit.ipv4;
  assign closing = live && ctl_exit.close;

  // bandwidth limit in bits per window, follows the register
  always_ff @(posedge clk) begin
    lim <= LIM_W'(mbps_limit) * LIM_W'(MEGA);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_count <= '0;
      tcp_count <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rep_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= ctl_exit.valid;
      s2_valid  <= s1_valid;
      rep_valid <= s2_valid;
      if (closing) begin
        pkt_count <= '0;
        tcp_count <= '0;
      end else if (live) begin
        pkt_count <= pkt_inc;
        if (ctl_exit.tcp) begin
          tcp_count <= tcp_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_alert <= live && ctl_exit.tcp && (CONN_W'(cnt_exit) > CONN_W'(conn_limit));
      s1_close <= closing;
      s1_pkt   <= closing ? pkt_inc : '0;
      s1_tcp   <= closing ? (ctl_exit.tcp ? tcp_inc : tcp_count) : '0;
      s1_conn  <= closing ? cnt_exit : '0;

      s2_alert <= s1_alert;
      s2_close <= s1_close;
      s2_pkt   <= s1_pkt;
      s2_tcp   <= s1_tcp;
      s2_conn  <= s1_conn;
      s2_rate  <= s1_close && (PPS_W'(s1_pkt) > PPS_W'(pps_limit));
      s2_prod  <= PROD_W'(s1_pkt) * PROD_W'(mtu_bytes);

      connection_alert     <= s2_alert;
      rate_alert           <= s2_rate;
      bandwidth_alert      <= s2_close && (BW_W'({s2_prod, 3'b000}) > BW_W'(lim));
      window_closed        <= s2_close;
      packets_reported     <= 24'(s2_pkt);
      tcp_reported         <= 24'(s2_tcp);
      connections_reported <= 10'(s2_conn);
    end
  end

  a_open_window_quiet : assert property (@(posedge clk) disable iff (rst)
    rep_valid && !window_closed |->
      packets_reported == '0 && tcp_reported == '0 && !rate_alert && !bandwidth_alert)
    else $error("result of an open window carries window data");

  a_close_clears : assert property (@(posedge clk) disable iff (rst)
    adv && closing |=> pkt_count == '0 && tcp_count == '0)
    else $error("window counters not cleared after close");

  a_miss_means_full : assert property (@(posedge clk) disable iff (rst)
    ctl_exit.valid && ctl_exit.ipv4 && ctl_exit.tcp && !ctl_exit.hit |->
      cnt_exit == CNT_BITS'(ENTRIES))
    else $error("TCP key left the row unplaced while the table had room");

endmodule

>>> rtl/core/traffic_window_monitor.sv
// Top level of the traffic window monitor.
//
//   channel  direction  handshake               contents
//   pkt      in         pkt_valid / pkt_stall   packet header fields
//   rep      out        rep_valid / rep_stall   alerts and window counts
//   cfg      in         cfg_write               cfg_index, cfg_data
//
// A packet passes from transfer to result through one input register, one
// register per table cell as its key walks the cell row, and three report
// stages (count update, multiply, compare). One packet enters per cycle unless stalled.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result freezes the whole pipeline, and pkt_stall follows it.
`timescale 1ns / 1ps
module traffic_window_monitor #(
  parameter int TABLE_ENTRIES = 512,
  parameter int COUNT_BITS    = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [twm_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [twm_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                         pkt_valid,
  output logic                         pkt_stall,
  input  logic [3:0]                   ip_version,
  input  logic [7:0]                   ip_protocol,
  input  logic [31:0]                  source_address,
  input  logic [15:0]                  source_port,
  input  logic                         second_elapsed,
  output logic                         rep_valid,
  input  logic                         rep_stall,
  output logic                         connection_alert,
  output logic                         rate_alert,
  output logic                         bandwidth_alert,
  output logic                         window_closed,
  output logic [23:0]                  packets_reported,
  output logic [23:0]                  tcp_reported,
  output logic [9:0]                   connections_reported
);
  import twm_pkg::*;

  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

  logic [23:0]         pps_limit;
  logic [16:0]         mbps_limit;
  logic [8:0]          conn_limit;
  logic [15:0]         mtu_bytes;
  logic                adv;
  twm_ctl_t            ctl_head;
  logic [KEY_BITS-1:0] key_head;
  twm_ctl_t            ctl_exit;
  logic [CNT_BITS-1:0] cnt_exit;

  assign adv       = !rep_valid || !rep_stall;
  assign pkt_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pps_limit  <= PPS_LIMIT_RESET;
      mbps_limit <= MBPS_LIMIT_RESET;
      conn_limit <= CONN_LIMIT_RESET;
      mtu_bytes  <= MTU_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (twm_reg_t'(cfg_index))
        REG_PPS_LIMIT:  pps_limit  <= cfg_data[23:0];
        REG_MBPS_LIMIT: mbps_limit <= cfg_data[16:0];
        REG_CONN_LIMIT: conn_limit <= cfg_data[8:0];
        REG_MTU_BYTES:  mtu_bytes  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register: decode the header into a token
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_head <= '0;
    end else if (adv) begin
      ctl_head.valid <= pkt_valid;
      ctl_head.ipv4  <= (ip_version == IP_V4);
      ctl_head.tcp   <= (ip_protocol == PROTO_TCP);
      ctl_head.close <= second_elapsed;
      ctl_head.hit   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_head <= {source_address, source_port};
    end
  end

  twm_chain #(
    .ENTRIES  (TABLE_ENTRIES),
    .CNT_BITS (CNT_BITS)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (ctl_head),
    .key_in  (key_head),
    .ctl_out (ctl_exit),
    .cnt_out (cnt_exit)
  );

  twm_report #(
    .ENTRIES    (TABLE_ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .CNT_BITS   (CNT_BITS)
  ) u_report (
    .clk                  (clk),
    .rst                  (rst),
    .adv                  (adv),
    .ctl_exit             (ctl_exit),
    .cnt_exit             (cnt_exit),
    .pps_limit            (pps_limit),
    .mbps_limit           (mbps_limit),
    .conn_limit           (conn_limit),
    .mtu_bytes            (mtu_bytes),
    .rep_valid            (rep_valid),
    .connection_alert     (connection_alert),
    .rate_alert           (rate_alert),
    .bandwidth_alert      (bandwidth_alert),
    .window_closed        (window_closed),
    .packets_reported     (packets_reported),
    .tcp_reported         (tcp_reported),
    .connections_reported (connections_reported)
  );

endmodule

>>> tb/sv/tb_traffic_window_monitor.sv
// Self-checking testbench for the traffic window monitor: directed and random packets.
`timescale 1ns / 1ps
module tb_traffic_window_monitor;
  import twm_pkg::*;

  localparam int TBL_ENTRIES = 512;
  // Counter width of the monitor under test.
  localparam int CNT_BITS = 24;
  localparam int unsigned CNT_MAX = (1 << CNT_BITS) - 1;
  localparam int LATENCY = TBL_ENTRIES + 4;

  typedef struct packed {
    logic        conn_alert;
    logic        rate;
    logic        bw;
    logic        closed;
    logic [23:0] pkts;
    logic [23:0] tcps;
    logic [9:0]  conns;
  } report_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic                pkt_valid;
  logic                pkt_stall;
  logic [3:0]          ip_version;
  logic [7:0]          ip_protocol;
  logic [31:0]         source_address;
  logic [15:0]         source_port;
  logic                second_elapsed;
  logic                rep_valid;
  logic                rep_stall;
  logic                connection_alert;
  logic                rate_alert;
  logic                bandwidth_alert;
  logic                window_closed;
  logic [23:0]         packets_reported;
  logic [23:0]         tcp_reported;
  logic [9:0]          connections_reported;

  traffic_window_monitor #(
    .TABLE_ENTRIES(TBL_ENTRIES),
    .COUNT_BITS   (CNT_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pkt_valid           (pkt_valid),
    .pkt_stall           (pkt_stall),
    .ip_version          (ip_version),
    .ip_protocol         (ip_protocol),
    .source_address      (source_address),
    .source_port         (source_port),
    .second_elapsed      (second_elapsed),
    .rep_valid           (rep_valid),
    .rep_stall           (rep_stall),
    .connection_alert    (connection_alert),
    .rate_alert          (rate_alert),
    .bandwidth_alert     (bandwidth_alert),
    .window_closed       (window_closed),
    .packets_reported    (packets_reported),
    .tcp_reported        (tcp_reported),
    .connections_reported(connections_reported)
  );

  // Shadow limits and window state of the monitor.
  logic [23:0]        pps_lim  = PPS_LIMIT_RESET;
  logic [16:0]        mbps_lim = MBPS_LIMIT_RESET;
  logic [8:0]         conn_lim = CONN_LIMIT_RESET;
  logic [15:0]        mtu      = MTU_BYTES_RESET;
  int unsigned        win_pkts  = 0;
  int unsigned        win_tcp   = 0;
  int unsigned        win_conns = 0;
  bit                 conn_seen [logic [47:0]];
  report_t            expected_reports [$];
  logic [47:0]        key_pool [16];
  int                 mismatches = 0;
  bit                 send_idle = 1'b1;
  bit                 recv_idle = 1'b1;
  int                 hold_req  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned sat_inc(input int unsigned v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1;
  endfunction

  function automatic report_t predict_report(input logic [3:0] ver, input logic [7:0] proto,
                                             input logic [31:0] addr, input logic [15:0] port,
                                             input logic tick);
    report_t     r;
    logic [47:0] key;
    logic [63:0] bits;
    logic [63:0] lim;
    r = '0;
    if (ver != IP_V4) return r;
    win_pkts = sat_inc(win_pkts);
    if (proto == PROTO_TCP) begin
      win_tcp = sat_inc(win_tcp);
      key = {addr, port};
      // A full table drops new keys but still matches stored ones.
      if (!conn_seen.exists(key) && win_conns < TBL_ENTRIES) begin
        conn_seen[key] = 1'b1;
        win_conns++;
      end
      r.conn_alert = (win_conns > conn_lim);
    end
    if (tick) begin
      bits = 64'(win_pkts) * 64'(mtu) * 64'd8;
      lim = 64'(mbps_lim) * 64'd1000000;
      r.rate = (win_pkts > pps_lim);
      r.bw = (bits > lim);
      r.closed = 1'b1;
      r.pkts = 24'(win_pkts);
      r.tcps = 24'(win_tcp);
      r.conns = 10'(win_conns);
      win_pkts = 0;
      win_tcp = 0;
      win_conns = 0;
      conn_seen.delete();
    end
    return r;
  endfunction

  // Enter and leave at a falling edge; valid stays high for a following item.
  task automatic send_pkt(input logic [3:0] ver, input logic [7:0] proto,
                          input logic [31:0] addr, input logic [15:0] port, input logic tick);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ip_version <= ver;
    ip_protocol <= proto;
    source_address <= addr;
    source_port <= port;
    second_elapsed <= tick;
    pkt_valid <= 1'b1;
    do @(posedge clk); while (pkt_stall);
    expected_reports.push_back(predict_report(ver, proto, addr, port, tick));
    @(negedge clk);
  endtask

  task automatic drain();
    pkt_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input twm_reg_t idx, input logic [CFG_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_PPS_LIMIT:  pps_lim = value[23:0];
      REG_MBPS_LIMIT: mbps_lim = value[16:0];
      REG_CONN_LIMIT: conn_lim = value[8:0];
      REG_MTU_BYTES:  mtu = value[15:0];
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Junk in the unused upper data bits must be ignored.
  task automatic write_all(input logic [23:0] pps, input logic [16:0] mbps,
                           input logic [8:0] conn, input logic [15:0] mtu_val);
    write_reg(REG_PPS_LIMIT, pps);
    write_reg(REG_MBPS_LIMIT, {7'($urandom), mbps});
    write_reg(REG_CONN_LIMIT, {15'($urandom), conn});
    write_reg(REG_MTU_BYTES, {8'($urandom), mtu_val});
  endtask

  task automatic rand_limits();
    logic [23:0] pps;
    logic [16:0] mbps;
    logic [8:0]  conn;
    logic [15:0] mtu_val;
    case ($urandom_range(0, 3))
      0:       pps = '0;
      1:       pps = '1;
      default: pps = 24'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 3))
      0:       mbps = '0;
      1:       mbps = '1;
      2:       mbps = 17'($urandom);
      default: mbps = 17'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 2))
      0:       conn = '0;
      1:       conn = 9'd511;
      default: conn = 9'($urandom_range(0, 24));
    endcase
    case ($urandom_range(0, 3))
      0:       mtu_val = 16'd68;
      1:       mtu_val = '1;
      2:       mtu_val = 16'($urandom);
      default: mtu_val = 16'($urandom_range(0, 1500));
    endcase
    write_all(pps, mbps, conn, mtu_val);
  endtask

  // Mostly IPv4 with repeating connections; the rest is raw noise.
  task automatic send_random(input int n);
    logic [47:0] key;
    logic [7:0]  proto;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_pkt(4'($urandom), 8'($urandom), $urandom, 16'($urandom), 1'($urandom));
      end else begin
        key = key_pool[4'($urandom_range(0, 15))];
        if ($urandom_range(0, 1) != 0) key = {$urandom, 16'($urandom)};
        proto = ($urandom_range(0, 3) != 0) ? PROTO_TCP : 8'($urandom);
        send_pkt(IP_V4, proto, key[47:16], key[15:0], $urandom_range(0, 19) == 0);
      end
    end
  endtask

  task automatic test_packet_kinds();
    send_pkt(4'd0, PROTO_TCP, 32'h0A00_0001, 16'd80, 1'b1);
    send_pkt(4'hF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h0, 16'h0, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h0, 16'h0, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'hFFFF_FFFF, 16'h0, 1'b0);
    send_pkt(IP_V4, 8'd17, $urandom, 16'($urandom_range(0, 65535)), 1'b0);
    send_pkt(IP_V4, 8'd0, $urandom, 16'($urandom_range(0, 65535)), 1'b0);
    send_pkt(IP_V4, 8'hFF, $urandom, 16'($urandom_range(0, 65535)), 1'b0);
    send_pkt(IP_V4, 8'd7, $urandom, 16'($urandom_range(0, 65535)), 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h0, 16'hFFFF, 1'b1);
    send_pkt(IP_V4, 8'd1, $urandom, 16'($urandom_range(0, 65535)), 1'b1);
    send_pkt(4'd6, 8'd17, $urandom, 16'($urandom_range(0, 65535)), 1'b1);
    send_pkt(4'd5, PROTO_TCP, $urandom, 16'($urandom_range(0, 65535)), 1'b1);
    drain();
  endtask

  task automatic test_limit_extremes();
    // Every limit at zero: all alerts fire.
    write_all(24'd0, 17'd0, 9'd0, 16'hFFFF);
    send_pkt(IP_V4, PROTO_TCP, 32'h1, 16'h1, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h1, 16'h1, 1'b0);
    send_pkt(IP_V4, 8'd17, 32'h2, 16'h2, 1'b1);
    drain();
    // Every limit at its top: nothing fires.
    write_all(24'hFF_FFFF, 17'h1_FFFF, 9'd511, 16'd0);
    send_pkt(IP_V4, PROTO_TCP, 32'h3, 16'h3, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h4, 16'h4, 1'b1);
    drain();
    // Exactly at the rate and bandwidth thresholds, then one packet past them.
    write_all(24'd2, 17'd1, 9'd1, 16'd62500);
    send_pkt(IP_V4, PROTO_TCP, 32'h5, 16'h5, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h6, 16'h6, 1'b1);
    send_pkt(IP_V4, PROTO_TCP, 32'h5, 16'h5, 1'b0);
    send_pkt(IP_V4, 8'd17, 32'h6, 16'h6, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h5, 16'h5, 1'b1);
    drain();
    write_all(24'd1000, 17'd100000, 9'd500, 16'd68);
    send_pkt(IP_V4, PROTO_TCP, 32'h7, 16'h7, 1'b1);
    drain();
  endtask

  task automatic test_table_full();
    write_all(24'd254, 17'd2, 9'd511, 16'd1500);
    send_idle = 1'b0;
    // More distinct keys than the table holds.
    for (int i = 0; i < TBL_ENTRIES + 8; i++)
      send_pkt(IP_V4, PROTO_TCP, 32'hC0A8_0000 + i, 16'(i) ^ 16'h5A5A, 1'b0);
    for (int i = 0; i < 8; i++)
      send_pkt(IP_V4, PROTO_TCP, 32'hC0A8_0000 + i, 16'(i) ^ 16'h5A5A, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'h0A0A_0A0A, 16'h1234, 1'b1);
    // Table must come back empty after the close.
    send_pkt(IP_V4, PROTO_TCP, 32'hC0A8_0000, 16'h5A5A, 1'b0);
    send_pkt(IP_V4, PROTO_TCP, 32'hC0A8_0001, 16'h5A5B, 1'b1);
    send_idle = 1'b1;
    drain();
  endtask

  task automatic test_random_windows(input int phases);
    for (int p = 0; p < phases; p++) begin
      rand_limits();
      recv_idle = (p % 3 != 0);
      send_idle = (p % 4 != 1);
      send_random(50);
      drain();
    end
    recv_idle = 1'b1;
    send_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    rand_limits();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    // Takes effect after the first report, once the pipeline is full.
    hold_req = 600;
    send_random(640);
    drain();
    recv_idle = 1'b1;
    send_idle = 1'b1;
    send_random(40);
    drain();
  endtask

  // Report side: draw a stall per transfer, or serve a requested long hold.
  initial begin : report_sink
    int n;
    rep_stall = 1'b0;
    forever begin
      n = recv_idle ? $urandom_range(0, 18) : 0;
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        @(negedge clk) rep_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) rep_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rep_valid && !rep_stall));
    end
  end

  always @(posedge clk) begin : report_check
    report_t got;
    report_t want;
    if (!rst && rep_valid && !rep_stall) begin
      got = {connection_alert, rate_alert, bandwidth_alert, window_closed,
             packets_reported, tcp_reported, connections_reported};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("report with nothing pending: %h", got);
      end else begin
        want = expected_reports.pop_front();
        if (got.conn_alert !== want.conn_alert || got.rate !== want.rate ||
            got.bw !== want.bw || got.closed !== want.closed ||
            got.pkts !== want.pkts || got.tcps !== want.tcps ||
            got.conns !== want.conns) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch: exp conn_al=%0d rate=%0d bw=%0d closed=%0d",
                     want.conn_alert, want.rate, want.bw, want.closed,
                     " pkts=%0d tcp=%0d conns=%0d", want.pkts, want.tcps, want.conns);
            $display("                 got conn_al=%0d rate=%0d bw=%0d closed=%0d",
                     got.conn_alert, got.rate, got.bw, got.closed,
                     " pkts=%0d tcp=%0d conns=%0d", got.pkts, got.tcps, got.conns);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_PPS_LIMIT;
    cfg_data = '0;
    pkt_valid = 1'b0;
    ip_version = '0;
    ip_protocol = '0;
    source_address = '0;
    source_port = '0;
    second_elapsed = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, 16'($urandom)};
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);

    test_packet_kinds();
    test_limit_extremes();
    test_table_full();
    test_random_windows(10);
    test_backpressure();

    drain();
    repeat (LATENCY + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
